// ===== hw/rtl/kmpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmpf_pkg
// Types and constants shared by the KMP first-match finder modules.
// ----------------------------------------------------------------------------
package kmpf_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
   localparam int POS_W       = 32;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEXT   = 2'd2,
      CMD_END    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_NONE     = 2'd0,
      ST_FOUND    = 2'd1,
      ST_NO_MATCH = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_WALK = 1'b1
   } state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [POS_W-1:0] match_position;
   } rsp_item_type;

   // write request into the cell row
   typedef struct packed {
      logic             byte_en;
      logic             fail_en;
      logic [IDX_W-1:0] idx;
      logic [7:0]       pat_byte;
      logic [CNT_W-1:0] fail;
   } wr_type;

   // what one cell shows to the walk logic
   typedef struct packed {
      logic             hit;
      logic [CNT_W-1:0] link;
   } tap_type;

endpackage
`default_nettype wire

// ===== hw/rtl/kmpf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmpf_cell
// One pattern position: holds its byte and failure value, compares the
// probe byte and passes its failure value on to the next cell.
// ----------------------------------------------------------------------------
module kmpf_cell (
   input  wire logic                      clock,
   input  wire logic                      wr_byte_en,
   input  wire logic                      wr_fail_en,
   input  wire logic [7:0]                pat_byte_wr,
   input  wire logic [kmpf_pkg::CNT_W-1:0] fail_wr,
   input  wire logic [7:0]                probe,
   input  wire logic [kmpf_pkg::CNT_W-1:0] link_in,
   output kmpf_pkg::tap_type              tap,
   output logic [kmpf_pkg::CNT_W-1:0]     fail_out
);

   logic [7:0]                 pat_byte_ff;
   logic [7:0]                 pat_byte_in;
   logic [kmpf_pkg::CNT_W-1:0] fail_ff;
   logic [kmpf_pkg::CNT_W-1:0] fail_in;

   always_comb begin
      pat_byte_in = wr_byte_en ? pat_byte_wr : pat_byte_ff;
      fail_in     = wr_fail_en ? fail_wr : fail_ff;
   end

   always_ff @(posedge clock) begin
      pat_byte_ff <= pat_byte_in;
      fail_ff     <= fail_in;
   end

   // link is the failure value of the previous position
   assign tap.hit  = (pat_byte_ff == probe);
   assign tap.link = link_in;
   assign fail_out = fail_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/kmpf_cell_row.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmpf_cell_row
// Row of pattern cells with write decode and the tap select at the
// index sel_idx.
// ----------------------------------------------------------------------------
module kmpf_cell_row (
   input  wire logic                      clock,
   input  wire kmpf_pkg::wr_type          wr,
   input  wire logic [7:0]                probe,
   input  wire logic [kmpf_pkg::IDX_W-1:0] sel_idx,
   output kmpf_pkg::tap_type              tap_sel
);

   kmpf_pkg::tap_type          taps  [kmpf_pkg::MAX_PATTERN];
   logic [kmpf_pkg::CNT_W-1:0] fails [kmpf_pkg::MAX_PATTERN];

   for (genvar i = 0; i < kmpf_pkg::MAX_PATTERN; i++) begin : g_cell
      logic                       hit_wr;
      logic [kmpf_pkg::CNT_W-1:0] link_in;

      assign hit_wr = (wr.idx == kmpf_pkg::IDX_W'(i));

      if (i == 0) begin : g_first
         assign link_in = '0;
      end else begin : g_rest
         assign link_in = fails[i-1];
      end

      kmpf_cell u_cell (
         .clock       (clock),
         .wr_byte_en  (wr.byte_en & hit_wr),
         .wr_fail_en  (wr.fail_en & hit_wr),
         .pat_byte_wr (wr.pat_byte),
         .fail_wr     (wr.fail),
         .probe       (probe),
         .link_in     (link_in),
         .tap         (taps[i]),
         .fail_out    (fails[i])
      );
   end

   assign tap_sel = taps[sel_idx];

endmodule
`default_nettype wire

// ===== hw/rtl/kmp_first_match_finder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_first_match_finder_unit
// Byte-serial Knuth-Morris-Pratt first-match finder.
// ----------------------------------------------------------------------------
// Every input item yields exactly one result item. Clear, end of text,
// refused appends, the first pattern byte, text with an empty pattern and
// text after a match go straight to the result register. An append of a
// later pattern byte and a text byte during a search walk the failure chain
// through the cell row, one chain link per cycle, before the result is
// written. One item is in work at a time; a new item is taken once the
// walk is over and the result register is free or being read.
// ----------------------------------------------------------------------------
module kmp_first_match_finder_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire kmpf_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output kmpf_pkg::rsp_item_type rsp_item
);

   localparam logic [kmpf_pkg::CNT_W-1:0] MaxCnt = kmpf_pkg::CNT_W'(kmpf_pkg::MAX_PATTERN);

   kmpf_pkg::state_type state_ff, state_in;
   logic                            append_ff, append_in;
   logic [7:0]                      probe_ff, probe_in;
   logic [kmpf_pkg::CNT_W-1:0]      k_ff, k_in;
   logic [kmpf_pkg::CNT_W-1:0]      size_ff, size_in;
   logic [kmpf_pkg::CNT_W-1:0]      matched_ff, matched_in;
   logic [kmpf_pkg::POS_W-1:0]      tpos_ff, tpos_in;
   logic                            found_ff, found_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   kmpf_pkg::rsp_item_type          rsp_item_ff, rsp_item_in;

   kmpf_pkg::wr_type                wr;
   kmpf_pkg::tap_type               tap;

   logic                            accept;
   logic                            start_walk;
   logic                            in_range;
   logic                            step_back;
   logic [kmpf_pkg::CNT_W-1:0]      k_final;
   logic [kmpf_pkg::IDX_W-1:0]      sel_idx;
   kmpf_pkg::cmd_type               cmd;

   // idle: tap at the pattern end, so its link is the last failure value
   assign sel_idx = (state_ff == kmpf_pkg::S_IDLE) ? size_ff[kmpf_pkg::IDX_W-1:0]
                                                   : k_ff[kmpf_pkg::IDX_W-1:0];

   kmpf_cell_row u_row (
      .clock   (clock),
      .wr      (wr),
      .probe   (probe_ff),
      .sel_idx (sel_idx),
      .tap_sel (tap)
   );

   assign req_ready = (state_ff == kmpf_pkg::S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign cmd       = kmpf_pkg::cmd_type'(req_item.command);
   assign in_range  = (k_ff < MaxCnt);
   assign step_back = (k_ff != '0) && in_range && !tap.hit;
   assign k_final   = (in_range && tap.hit) ? k_ff + 1'b1 : k_ff;

   always_comb begin
      start_walk = 1'b0;
      if (accept) begin
         case (cmd)
            kmpf_pkg::CMD_APPEND: start_walk = (size_ff < MaxCnt) && (size_ff != '0);
            kmpf_pkg::CMD_TEXT:   start_walk = !found_ff && (size_ff != '0);
            default:              start_walk = 1'b0;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kmpf_pkg::S_IDLE: if (start_walk) state_in = kmpf_pkg::S_WALK;
         kmpf_pkg::S_WALK: if (!step_back) state_in = kmpf_pkg::S_IDLE;
         default:          state_in = kmpf_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      append_in    = append_ff;
      probe_in     = probe_ff;
      k_in         = k_ff;
      size_in      = size_ff;
      matched_in   = matched_ff;
      tpos_in      = tpos_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      wr           = '0;
      wr.idx       = size_ff[kmpf_pkg::IDX_W-1:0];
      wr.pat_byte  = req_item.data_byte;
      wr.fail      = k_final;

      case (state_ff)
         kmpf_pkg::S_IDLE: begin
            if (accept) begin
               append_in   = (cmd == kmpf_pkg::CMD_APPEND);
               probe_in    = req_item.data_byte;
               rsp_item_in = '{status: kmpf_pkg::ST_NONE, match_position: '0};
               case (cmd)
                  kmpf_pkg::CMD_CLEAR: begin
                     size_in      = '0;
                     matched_in   = '0;
                     tpos_in      = '0;
                     found_in     = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  kmpf_pkg::CMD_APPEND: begin
                     if (size_ff >= MaxCnt) begin
                        rsp_item_in.status = kmpf_pkg::ST_OVERFLOW;
                        rsp_valid_in       = 1'b1;
                     end else begin
                        wr.byte_en = 1'b1;
                        if (size_ff == '0) begin
                           wr.fail_en   = 1'b1;
                           wr.fail      = '0;
                           size_in      = size_ff + 1'b1;
                           rsp_valid_in = 1'b1;
                        end else begin
                           k_in = tap.link;
                        end
                     end
                  end
                  kmpf_pkg::CMD_TEXT: begin
                     if (found_ff) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        if (tpos_ff != '1) tpos_in = tpos_ff + 1'b1;
                        k_in = matched_ff;
                        if (size_ff == '0) rsp_valid_in = 1'b1;
                     end
                  end
                  kmpf_pkg::CMD_END: begin
                     if (!found_ff) rsp_item_in.status = kmpf_pkg::ST_NO_MATCH;
                     matched_in   = '0;
                     tpos_in      = '0;
                     found_in     = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         kmpf_pkg::S_WALK: begin
            if (step_back) begin
               k_in = tap.link;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{status: kmpf_pkg::ST_NONE, match_position: '0};
               if (append_ff) begin
                  wr.fail_en = 1'b1;
                  size_in    = size_ff + 1'b1;
               end else begin
                  matched_in = k_final;
                  if (k_final >= size_ff) begin
                     found_in                   = 1'b1;
                     rsp_item_in.status         = kmpf_pkg::ST_FOUND;
                     rsp_item_in.match_position = tpos_ff - kmpf_pkg::POS_W'(size_ff) + 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // walk start index for an append is the previous position's failure value
   // (read as the link of cell size_ff through the idle tap select)

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kmpf_pkg::S_IDLE;
         size_ff      <= '0;
         matched_ff   <= '0;
         tpos_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         matched_ff   <= matched_in;
         tpos_ff      <= tpos_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      append_ff   <= append_in;
      probe_ff    <= probe_in;
      k_ff        <= k_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_walk_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == kmpf_pkg::S_WALK |-> !rsp_valid_ff)
      else $error("result register busy during walk");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == kmpf_pkg::S_WALK |-> k_ff < size_ff)
      else $error("walk index beyond pattern");

   a_matched_bound: assert property (@(posedge clock) disable iff (reset)
      matched_ff <= size_ff && size_ff <= MaxCnt)
      else $error("match count beyond pattern size");

   a_found_nonempty: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> size_ff != '0)
      else $error("match with empty pattern");

endmodule
`default_nettype wire
